/* hw/rtl/ipacl_pkg.sv */
package ipacl_pkg;

    // Default table depth
    localparam int MAX_RULES_DEF = 16;

    // Stream payload widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // Request kinds carried on tuser
    localparam logic REQ_CONFIG = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Rule modes
    localparam logic MODE_CONNECT = 1'b0;
    localparam logic MODE_BIND    = 1'b1;

    // Load status codes (also used as the sticky error code)
    localparam logic [1:0] STAT_LOADING = 2'd0;
    localparam logic [1:0] STAT_OK      = 2'd1;
    localparam logic [1:0] STAT_SYNTAX  = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // Parser phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_LINE     = 4'd1;
    localparam logic [3:0] PH_COMMENT  = 4'd2;
    localparam logic [3:0] PH_KEYWORD  = 4'd3;
    localparam logic [3:0] PH_KWSKIP   = 4'd4;
    localparam logic [3:0] PH_MODE     = 4'd5;
    localparam logic [3:0] PH_SEP      = 4'd6;
    localparam logic [3:0] PH_OCTSTART = 4'd7;
    localparam logic [3:0] PH_DIGITS   = 4'd8;
    localparam logic [3:0] PH_TAILSKIP = 4'd9;

    // Characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_P     = 8'h70;

    localparam logic [2:0]  KW_LEN    = 3'd6;
    localparam logic [11:0] OCTET_MAX = 12'd255;

    // One stored rule
    typedef struct packed {
        logic        kind;
        logic [3:0]  wild;
        logic [31:0] addr;
    } rule_t;

    // One result
    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic       verdict;
        logic [4:0] loaded;
    } result_t;

    // Expected character of the "permit" keyword at a position
    function automatic logic [7:0] kw_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h70;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h72;
            3'd3:    ch = 8'h6D;
            3'd4:    ch = 8'h69;
            3'd5:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/ip_acl_rule_parse_and_match.sv */
// IPv4 wildcard access list: rule text loader and query matcher.
// Input stream carries two request kinds, selected by s_axis_tuser:
//   config request: one ASCII byte of rule text, s_axis_tlast on the final byte.
//     The first byte of a load empties the table. Each is parsed combinationally;
//     its result (status, rule count) is queued on the edge it is accepted.
//   query request: mode and address; the rule table is scanned one rule per
//     cycle out of a synchronous RAM with a registered read, stopping at the
//     first hit. When the table is empty the result is queued on the edge the
//     query is accepted.
// One request is worked on at a time. Results leave through a two-entry output
// queue, so a new request is taken while one result still waits downstream.
// When the receiver stalls with both queue entries full, s_axis_tready drops.
// Reset empties the table count, returns the parser to the start of a new load
// and empties the output queue. The RAM contents are not cleared; only entries
// below the rule count are ever compared.
module ip_acl_rule_parse_and_match
    import ipacl_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] config_byte, [8] query_cmd, [40:9] query_ip, [47:41] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    // [0] req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] load_status, [2] verdict, [7:3] rules_loaded
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] resp_kind
    output logic                   m_axis_tuser
);

    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Control state
    logic          st_reg, st_next;
    logic [3:0]    phase_reg, phase_next;
    logic [2:0]    kw_reg, kw_next;
    logic [1:0]    oidx_reg, oidx_next;
    logic [7:0]    acc_reg, acc_next;
    logic [31:0]   paddr_reg, paddr_next;
    logic [3:0]    pwild_reg, pwild_next;
    logic          pkind_reg, pkind_next;
    logic [1:0]    err_reg, err_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cmp_idx_reg;
    logic          rdv_reg, rdv_next;
    logic          cmd_reg;
    logic [31:0]   ip_reg;

    // Rule RAM
    rule_t         rule_mem [MAX_RULES];
    rule_t         rd_rule_reg;
    rule_t         wr_rule;
    logic [IW-1:0] wr_addr;
    logic          wr_en;

    // Output queue
    result_t       q0_reg, q1_reg;
    logic [1:0]    fcnt_reg;
    result_t       push_data;
    logic          push, pop;

    // Parser scratch
    logic [7:0]    ch;
    logic          ch_blank, ch_digit;
    logic [7:0]    ch_off;
    logic [11:0]   acc_sum;
    logic          do_start, commit_req;
    logic [1:0]    cfg_status;

    // Scan scratch
    logic          s_fire, cfg_fire, qry_fire;
    logic          issue, hit, cmp_last, finish;
    logic [31:0]   mask;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_fire = s_fire && (s_axis_tuser == REQ_CONFIG);
    assign qry_fire = s_fire && (s_axis_tuser == REQ_QUERY);

    assign s_axis_tready = (st_reg == ST_IDLE) && (fcnt_reg != 2'd2);

    // Decode the text byte
    assign ch       = s_axis_tdata[7:0];
    assign ch_blank = (ch == CH_SPACE) || (ch == CH_TAB);
    assign ch_digit = (ch >= CH_0) && (ch <= CH_9);
    assign ch_off   = ch - CH_0;
    assign acc_sum  = 12'({acc_reg, 3'b000}) + 12'({acc_reg, 1'b0}) + 12'(ch_off[3:0]);

    // Advance the parser by one config byte
    always_comb
    begin
        phase_next = phase_reg;
        kw_next    = kw_reg;
        oidx_next  = oidx_reg;
        acc_next   = acc_reg;
        paddr_next = paddr_reg;
        pwild_next = pwild_reg;
        pkind_next = pkind_reg;
        err_next   = err_reg;
        count_next = count_reg;
        do_start   = 1'b0;
        commit_req = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IW-1:0];
        cfg_status = STAT_LOADING;
        if (cfg_fire)
        begin
            if (phase_reg == PH_IDLE)
            begin
                count_next = '0;
                err_next   = STAT_LOADING;
                phase_next = PH_LINE;
            end
            if (err_next == STAT_LOADING)
            begin
                unique case (phase_next)
                    PH_LINE:
                    begin
                        if (ch == CH_HASH)
                            phase_next = PH_COMMENT;
                        else if (ch_blank || ch == CH_NL)
                            phase_next = PH_LINE;
                        else if (ch == CH_P)
                        begin
                            kw_next    = 3'd1;
                            paddr_next = '0;
                            pwild_next = '0;
                            pkind_next = MODE_CONNECT;
                            oidx_next  = '0;
                            acc_next   = '0;
                            phase_next = PH_KEYWORD;
                        end
                        else
                            err_next = STAT_SYNTAX;
                    end
                    PH_COMMENT:
                    begin
                        if (ch == CH_NL)
                            phase_next = PH_LINE;
                    end
                    PH_KEYWORD:
                    begin
                        if (kw_reg < KW_LEN && ch == kw_char(kw_reg))
                        begin
                            kw_next = kw_reg + 3'd1;
                            if (kw_next >= KW_LEN)
                                phase_next = PH_KWSKIP;
                        end
                        else
                            err_next = STAT_SYNTAX;
                    end
                    PH_KWSKIP:
                        phase_next = PH_MODE;
                    PH_MODE:
                    begin
                        if (ch_blank)
                            phase_next = PH_MODE;
                        else if (ch == CH_C || ch == CH_B)
                        begin
                            pkind_next = (ch == CH_B) ? MODE_BIND : MODE_CONNECT;
                            oidx_next  = '0;
                            phase_next = PH_SEP;
                        end
                        else
                            err_next = STAT_SYNTAX;
                    end
                    PH_SEP:
                    begin
                        if (ch_blank)
                            phase_next = PH_SEP;
                        else if (ch == CH_DOT)
                            phase_next = PH_OCTSTART;
                        else if (oidx_reg == 2'd0)
                            do_start = 1'b1;
                        else
                            err_next = STAT_SYNTAX;
                    end
                    PH_OCTSTART:
                    begin
                        if (!ch_blank)
                            do_start = 1'b1;
                    end
                    PH_DIGITS:
                    begin
                        if (ch_digit)
                        begin
                            if (acc_sum > OCTET_MAX)
                                err_next = STAT_SYNTAX;
                            else
                                acc_next = acc_sum[7:0];
                        end
                        else
                        begin
                            paddr_next = paddr_next
                                | ({24'b0, acc_next} << {2'd3 - oidx_next, 3'b000});
                            if (oidx_reg == 2'd3)
                            begin
                                commit_req = 1'b1;
                                phase_next = PH_LINE;
                            end
                            else if (ch_blank)
                            begin
                                oidx_next  = oidx_reg + 2'd1;
                                phase_next = PH_SEP;
                            end
                            else if (ch == CH_DOT)
                            begin
                                oidx_next  = oidx_reg + 2'd1;
                                phase_next = PH_OCTSTART;
                            end
                            else
                                err_next = STAT_SYNTAX;
                        end
                    end
                    default:
                        phase_next = PH_LINE;
                endcase

                // Open an octet: wildcard or first digit
                if (do_start)
                begin
                    if (ch == CH_STAR)
                    begin
                        pwild_next = pwild_next | (4'b0001 << oidx_next);
                        if (oidx_next == 2'd3)
                        begin
                            commit_req = 1'b1;
                            phase_next = PH_TAILSKIP;
                        end
                        else
                        begin
                            oidx_next  = oidx_next + 2'd1;
                            phase_next = PH_SEP;
                        end
                    end
                    else if (ch_digit)
                    begin
                        acc_next   = ch_off;
                        phase_next = PH_DIGITS;
                    end
                    else
                        err_next = STAT_SYNTAX;
                end
            end

            // Close the load on the last byte
            if (s_axis_tlast)
            begin
                if (err_next == STAT_LOADING)
                begin
                    if (phase_next == PH_DIGITS && oidx_next == 2'd3)
                    begin
                        paddr_next = paddr_next | {24'b0, acc_next};
                        commit_req = 1'b1;
                    end
                    else if (phase_next != PH_LINE && phase_next != PH_TAILSKIP)
                        err_next = STAT_SYNTAX;
                end
            end

            // Append the finished rule
            if (commit_req && err_next == STAT_LOADING)
            begin
                if (count_next >= CW'(MAX_RULES))
                    err_next = STAT_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_next[IW-1:0];
                    count_next = count_next + CW'(1);
                end
            end

            if (s_axis_tlast)
            begin
                cfg_status = (err_next != STAT_LOADING) ? err_next : STAT_OK;
                phase_next = PH_IDLE;
                kw_next    = '0;
                oidx_next  = '0;
                acc_next   = '0;
            end
        end
    end

    assign wr_rule = '{kind: pkind_next, wild: pwild_next, addr: paddr_next};

    // Rule RAM: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rule_mem[wr_addr] <= wr_rule;
        rd_rule_reg <= rule_mem[idx_reg[IW-1:0]];
    end

    // Compare the rule read in the previous cycle
    assign mask = {{8{rd_rule_reg.wild[0]}}, {8{rd_rule_reg.wild[1]}},
                   {8{rd_rule_reg.wild[2]}}, {8{rd_rule_reg.wild[3]}}};
    assign issue    = (st_reg == ST_SCAN) && (idx_reg < count_reg);
    assign hit      = rdv_reg && (rd_rule_reg.kind == cmd_reg)
                      && ((ip_reg & ~mask) == rd_rule_reg.addr);
    assign cmp_last = rdv_reg && ((cmp_idx_reg + CW'(1)) == count_reg);
    assign finish   = hit || cmp_last;

    // Sequence the scan
    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        rdv_next = issue && !finish;
        if (qry_fire)
        begin
            idx_next = '0;
            if (count_reg != '0)
                st_next = ST_SCAN;
        end
        else if (st_reg == ST_SCAN)
        begin
            if (issue)
                idx_next = idx_reg + CW'(1);
            if (finish)
                st_next = ST_IDLE;
        end
    end

    // Select the result to queue
    always_comb
    begin
        push      = 1'b0;
        push_data = '{kind: REQ_CONFIG, status: cfg_status, verdict: 1'b0,
                      loaded: 5'(count_next)};
        if (cfg_fire)
            push = 1'b1;
        else if (qry_fire && count_reg == '0)
        begin
            push      = 1'b1;
            push_data = '{kind: REQ_QUERY, status: STAT_LOADING, verdict: 1'b0,
                          loaded: 5'(count_reg)};
        end
        else if (finish)
        begin
            push      = 1'b1;
            push_data = '{kind: REQ_QUERY, status: STAT_LOADING, verdict: hit,
                          loaded: 5'(count_reg)};
        end
    end

    assign pop = m_axis_tvalid && m_axis_tready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            phase_reg <= PH_IDLE;
            kw_reg    <= '0;
            oidx_reg  <= '0;
            acc_reg   <= '0;
            paddr_reg <= '0;
            pwild_reg <= '0;
            pkind_reg <= MODE_CONNECT;
            err_reg   <= STAT_LOADING;
            count_reg <= '0;
            idx_reg   <= '0;
            rdv_reg   <= 1'b0;
            fcnt_reg  <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            kw_reg    <= kw_next;
            oidx_reg  <= oidx_next;
            acc_reg   <= acc_next;
            paddr_reg <= paddr_next;
            pwild_reg <= pwild_next;
            pkind_reg <= pkind_next;
            err_reg   <= err_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            rdv_reg   <= rdv_next;
            fcnt_reg  <= fcnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Query operands and scan position
    always_ff @(posedge clk)
    begin
        if (qry_fire)
        begin
            cmd_reg <= s_axis_tdata[8];
            ip_reg  <= s_axis_tdata[40:9];
        end
        if (issue)
            cmp_idx_reg <= idx_reg;
    end

    // Output queue: hold head in q0, spill into q1
    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (fcnt_reg == 2'd1)
                q0_reg <= push_data;
            else
            begin
                q0_reg <= q1_reg;
                q1_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (fcnt_reg == 2'd0)
                q0_reg <= push_data;
            else
                q1_reg <= push_data;
        end
        else if (pop)
            q0_reg <= q1_reg;
    end

    assign m_axis_tvalid = (fcnt_reg != 2'd0);
    assign m_axis_tuser  = q0_reg.kind;
    assign m_axis_tdata  = {q0_reg.loaded, q0_reg.verdict, q0_reg.status};

    // Queue never overflows
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fcnt_reg != 2'd2) || pop)
        else $error("result queue overflow");

    // Table count stays within the RAM depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count beyond table depth");

    // A compare only looks at an entry below the rule count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rdv_reg |-> (st_reg == ST_SCAN) && (cmp_idx_reg < count_reg))
        else $error("scan read past stored rules");

    // A config byte completes in the cycle it is taken
    a_cfg_single: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> (st_reg == ST_IDLE) && !rdv_reg)
        else $error("config request started a scan");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import ipacl_pkg::*;

    typedef logic [7:0] char_t;

    localparam int TABLE_DEPTH = MAX_RULES_DEF;
    localparam int ITEM_TARGET = 1000;

    // Shadow copy of the rule parser and table; predicts one result per request
    class acl_shadow;
        logic [31:0] tbl_addr [TABLE_DEPTH];
        logic [3:0]  tbl_wild [TABLE_DEPTH];
        logic        tbl_mode [TABLE_DEPTH];
        int          n_rules;
        logic [3:0]  phase;
        int          kw_pos;
        int          oct_idx;
        int          acc;
        logic [31:0] p_addr;
        logic [3:0]  p_wild;
        logic        p_mode;
        logic [1:0]  err;
        string       kw_text;
        result_t     pending_resp[$];
        int          n_fail;
        int          n_checked;
        int          n_loads;
        int          n_ok;
        int          n_syntax;
        int          n_full;
        int          n_queries;
        int          n_hits;

        function new();
            n_rules   = 0;
            phase     = PH_IDLE;
            kw_pos    = 0;
            oct_idx   = 0;
            acc       = 0;
            p_addr    = '0;
            p_wild    = '0;
            p_mode    = MODE_CONNECT;
            err       = STAT_LOADING;
            kw_text   = "permit";
            n_fail    = 0;
            n_checked = 0;
            n_loads   = 0;
            n_ok      = 0;
            n_syntax  = 0;
            n_full    = 0;
            n_queries = 0;
            n_hits    = 0;
        endfunction

        function bit is_blank(char_t c);
            return c == CH_SPACE || c == CH_TAB;
        endfunction

        function bit is_digit(char_t c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        // Keep the first error of a load
        function void set_error(logic [1:0] code);
            if (err == STAT_LOADING)
                err = code;
        endfunction

        function void store_rule();
            if (err != STAT_LOADING)
                return;
            if (n_rules >= TABLE_DEPTH)
            begin
                err = STAT_FULL;
                return;
            end
            tbl_addr[n_rules] = p_addr;
            tbl_wild[n_rules] = p_wild;
            tbl_mode[n_rules] = p_mode;
            n_rules++;
        endfunction

        function void place_octet();
            p_addr |= {24'd0, acc[7:0]} << (8 * (3 - oct_idx));
        endfunction

        function void begin_octet(char_t c);
            if (c == CH_STAR)
            begin
                p_wild[oct_idx] = 1'b1;
                if (oct_idx >= 3)
                begin
                    store_rule();
                    phase = PH_TAILSKIP;
                end
                else
                begin
                    oct_idx++;
                    phase = PH_SEP;
                end
            end
            else if (is_digit(c))
            begin
                acc   = int'(c) - int'(CH_0);
                phase = PH_DIGITS;
            end
            else
                set_error(STAT_SYNTAX);
        endfunction

        // Advance the parser by one text byte
        function void parse_char(char_t c);
            int v;
            unique case (phase)
                PH_LINE:
                begin
                    if (c == CH_HASH)
                        phase = PH_COMMENT;
                    else if (c == CH_P)
                    begin
                        kw_pos  = 1;
                        p_addr  = '0;
                        p_wild  = '0;
                        p_mode  = MODE_CONNECT;
                        oct_idx = 0;
                        acc     = 0;
                        phase   = PH_KEYWORD;
                    end
                    else if (!is_blank(c) && c != CH_NL)
                        set_error(STAT_SYNTAX);
                end
                PH_COMMENT:
                begin
                    if (c == CH_NL)
                        phase = PH_LINE;
                end
                PH_KEYWORD:
                begin
                    if (kw_pos < int'(KW_LEN) && c == kw_text[kw_pos])
                    begin
                        kw_pos++;
                        if (kw_pos >= int'(KW_LEN))
                            phase = PH_KWSKIP;
                    end
                    else
                        set_error(STAT_SYNTAX);
                end
                PH_KWSKIP:
                    phase = PH_MODE;
                PH_MODE:
                begin
                    if (c == CH_C || c == CH_B)
                    begin
                        p_mode  = (c == CH_B) ? MODE_BIND : MODE_CONNECT;
                        oct_idx = 0;
                        phase   = PH_SEP;
                    end
                    else if (!is_blank(c))
                        set_error(STAT_SYNTAX);
                end
                PH_SEP:
                begin
                    if (c == CH_DOT)
                        phase = PH_OCTSTART;
                    else if (is_blank(c))
                        phase = PH_SEP;
                    else if (oct_idx == 0)
                        begin_octet(c);
                    else
                        set_error(STAT_SYNTAX);
                end
                PH_OCTSTART:
                begin
                    if (!is_blank(c))
                        begin_octet(c);
                end
                PH_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        v = acc * 10 + int'(c) - int'(CH_0);
                        if (v > int'(OCTET_MAX))
                            set_error(STAT_SYNTAX);
                        else
                            acc = v;
                    end
                    else
                    begin
                        place_octet();
                        if (oct_idx >= 3)
                        begin
                            store_rule();
                            phase = PH_LINE;
                        end
                        else if (is_blank(c))
                        begin
                            oct_idx++;
                            phase = PH_SEP;
                        end
                        else if (c == CH_DOT)
                        begin
                            oct_idx++;
                            phase = PH_OCTSTART;
                        end
                        else
                            set_error(STAT_SYNTAX);
                    end
                end
                default:
                    phase = PH_LINE;
            endcase
        endfunction

        // Predict the result of one accepted request and queue it
        function void note_request(logic req, char_t c, logic last, logic cmd,
                                   logic [31:0] ip);
            result_t     exp;
            logic [31:0] mask;
            bit          hit;
            int          i;
            int          k;
            exp      = '0;
            exp.kind = req;
            if (req == REQ_CONFIG)
            begin
                if (phase == PH_IDLE)
                begin
                    n_rules = 0;
                    err     = STAT_LOADING;
                    phase   = PH_LINE;
                end
                if (err == STAT_LOADING)
                    parse_char(c);
                if (last)
                begin
                    if (err == STAT_LOADING)
                    begin
                        if (phase == PH_DIGITS && oct_idx >= 3)
                        begin
                            place_octet();
                            store_rule();
                        end
                        else if (phase != PH_LINE && phase != PH_TAILSKIP)
                            set_error(STAT_SYNTAX);
                    end
                    exp.status = (err != STAT_LOADING) ? err : STAT_OK;
                    phase   = PH_IDLE;
                    kw_pos  = 0;
                    oct_idx = 0;
                    acc     = 0;
                    n_loads++;
                    if (exp.status == STAT_OK)
                        n_ok++;
                    else if (exp.status == STAT_SYNTAX)
                        n_syntax++;
                    else
                        n_full++;
                end
            end
            else
            begin
                hit = 1'b0;
                for (i = 0; i < n_rules && !hit; i++)
                begin
                    if (tbl_mode[i] == cmd)
                    begin
                        mask = '0;
                        for (k = 0; k < 4; k++)
                            if (tbl_wild[i][k])
                                mask |= 32'hFF << (8 * (3 - k));
                        if ((ip & ~mask) == tbl_addr[i])
                            hit = 1'b1;
                    end
                end
                exp.verdict = hit;
                n_queries++;
                if (hit)
                    n_hits++;
            end
            exp.loaded = 5'(n_rules);
            pending_resp.push_back(exp);
        endfunction

        function void compare_field(string name, logic [4:0] exp, logic [4:0] got);
            if (got !== exp)
            begin
                n_fail++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_response(result_t got);
            result_t exp;
            if (pending_resp.size() == 0)
            begin
                n_fail++;
                $display("%0t: unexpected result kind=%0d status=%0d verdict=%0d loaded=%0d",
                         $time, got.kind, got.status, got.verdict, got.loaded);
                return;
            end
            exp = pending_resp.pop_front();
            n_checked++;
            compare_field("resp_kind", 5'(exp.kind), 5'(got.kind));
            compare_field("load_status", 5'(exp.status), 5'(got.status));
            compare_field("verdict", 5'(exp.verdict), 5'(got.verdict));
            compare_field("rules_loaded", exp.loaded, got.loaded);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    acl_shadow sb;
    bit        calm;
    int        n_sent;

    ip_acl_rule_parse_and_match #(
        .MAX_RULES     (TABLE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random, except in the calm window
    always @(negedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind    = m_axis_tuser;
            got.status  = m_axis_tdata[1:0];
            got.verdict = m_axis_tdata[2];
            got.loaded  = m_axis_tdata[7:3];
            sb.check_response(got);
        end
    end

    // Present one request from a falling edge and hold it until accepted
    task automatic push_request(logic req, char_t c, logic last, logic cmd,
                                logic [31:0] ip);
        calm = (n_sent >= 400 && n_sent < 550);
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ip, cmd, c};
        s_axis_tlast  <= last;
        s_axis_tuser  <= req;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(req, c, last, cmd, ip);
        n_sent++;
        @(negedge clk);
    endtask

    // Query near a stored rule most of the time, else anywhere
    task automatic send_query();
        int          idx;
        int          k;
        logic [31:0] ip;
        logic        cmd;
        if (sb.n_rules > 0 && $urandom_range(0, 2) != 0)
        begin
            idx = $urandom_range(0, sb.n_rules - 1);
            ip  = sb.tbl_addr[idx];
            for (k = 0; k < 4; k++)
                if (sb.tbl_wild[idx][k])
                    ip[8 * (3 - k) +: 8] = 8'($urandom_range(0, 255));
            cmd = sb.tbl_mode[idx];
            if ($urandom_range(0, 4) == 0)
                cmd = ~cmd;
            if ($urandom_range(0, 4) == 0)
                ip[$urandom_range(0, 31)] ^= 1'b1;
        end
        else
        begin
            ip  = $urandom;
            cmd = 1'($urandom_range(0, 1));
        end
        push_request(REQ_QUERY, char_t'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), cmd, ip);
    endtask

    // Stream one load, optionally with queries slipped in between bytes
    task automatic send_load(input char_t txt[$], input bit mix);
        int i;
        for (i = 0; i < txt.size(); i++)
        begin
            if (mix && $urandom_range(0, 11) == 0)
                send_query();
            push_request(REQ_CONFIG, txt[i], i == txt.size() - 1,
                         1'($urandom_range(0, 1)), $urandom);
        end
    endtask

    function automatic void load_string(string s, ref char_t txt[$]);
        int i;
        txt.delete();
        for (i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
    endfunction

    function automatic char_t pick_nondigit();
        char_t c;
        do
            c = char_t'($urandom_range(0, 255));
        while (c >= CH_0 && c <= CH_9);
        return c;
    endfunction

    function automatic void add_blanks(ref char_t txt[$], input int most);
        repeat ($urandom_range(0, most))
            txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_number(ref char_t txt[$], input int v);
        if (v >= 100)
            txt.push_back(CH_0 + 8'(v / 100));
        if (v >= 10)
            txt.push_back(CH_0 + 8'((v / 10) % 10));
        txt.push_back(CH_0 + 8'(v % 10));
    endfunction

    function automatic void add_comment(ref char_t txt[$]);
        char_t c;
        add_blanks(txt, 1);
        txt.push_back(CH_HASH);
        repeat ($urandom_range(0, 6))
        begin
            c = char_t'($urandom_range(0, 255));
            txt.push_back(c == CH_NL ? CH_SPACE : c);
        end
        txt.push_back(CH_NL);
    endfunction

    // One rule line with random spacing, octets and tail byte
    function automatic void add_rule(ref char_t txt[$]);
        string kw;
        int    i;
        int    k;
        int    r;
        int    v;
        bit    wild;
        kw = "permit";
        add_blanks(txt, 1);
        for (i = 0; i < kw.len(); i++)
            txt.push_back(kw[i]);
        txt.push_back($urandom_range(0, 3) == 0 ? char_t'($urandom_range(0, 255)) : CH_SPACE);
        add_blanks(txt, 1);
        txt.push_back($urandom_range(0, 1) ? CH_B : CH_C);
        add_blanks(txt, 1);
        if ($urandom_range(0, 3) == 0)
        begin
            txt.push_back(CH_DOT);
            add_blanks(txt, 1);
        end
        wild = 1'b0;
        for (k = 0; k < 4; k++)
        begin
            wild = ($urandom_range(0, 3) == 0);
            if (wild)
                txt.push_back(CH_STAR);
            else
            begin
                r = $urandom_range(0, 39);
                if (r == 0)
                    v = $urandom_range(256, 999);
                else if (r < 6)
                    v = 0;
                else if (r < 12)
                    v = 255;
                else
                    v = $urandom_range(0, 255);
                if ($urandom_range(0, 7) == 0)
                    txt.push_back(CH_0);
                add_number(txt, v);
            end
            if (k < 3)
            begin
                if (wild || $urandom_range(0, 2) == 0)
                    add_blanks(txt, 1);
                txt.push_back(CH_DOT);
                add_blanks(txt, 1);
            end
        end
        // Byte that ends the last octet, or the one skipped after a wildcard
        if (wild)
            txt.push_back(char_t'($urandom_range(0, 255)));
        else
        begin
            case ($urandom_range(0, 3))
                0: txt.push_back(CH_SPACE);
                1: txt.push_back(CH_TAB);
                2: txt.push_back(CH_NL);
                default: txt.push_back(pick_nondigit());
            endcase
        end
        txt.push_back(CH_NL);
    endfunction

    // Build one load: mostly well-formed, sometimes noise, cut short or damaged
    function automatic void build_load(int idx, ref char_t txt[$]);
        bit big;
        int n_lines;
        txt.delete();
        big = (idx % 4 == 2);
        if (!big && $urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                txt.push_back(char_t'($urandom_range(0, 255)));
            return;
        end
        n_lines = big ? $urandom_range(16, 18) : $urandom_range(0, 5);
        repeat (n_lines)
        begin
            if ($urandom_range(0, 5) == 0)
                add_comment(txt);
            add_rule(txt);
        end
        if ($urandom_range(0, 3) == 0)
            add_comment(txt);
        if (txt.size() == 0)
            txt.push_back(CH_NL);
        case ($urandom_range(0, 9))
            0:
                repeat ($urandom_range(1, 6))
                    if (txt.size() > 1)
                        void'(txt.pop_back());
            1:
                txt[$urandom_range(0, txt.size() - 1)] = char_t'($urandom_range(0, 255));
            2, 3:
                if (txt.size() > 1 && txt[txt.size() - 1] == CH_NL)
                    void'(txt.pop_back());
            default:
                txt.push_back(CH_NL);
        endcase
    endfunction

    // Give up if the run hangs
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        char_t txt[$];
        int    load_no;
        sb            = new();
        calm          = 1'b0;
        n_sent        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = REQ_CONFIG;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: query on an empty table
        push_request(REQ_QUERY, 8'hFF, 1'b1, MODE_BIND, 32'hFFFF_FFFF);
        // One bind rule, all-ones skip byte, wildcards and octet extremes
        load_string("permit b *.0.255.*", txt);
        txt[6] = 8'hFF;
        send_load(txt, 1'b0);
        push_request(REQ_QUERY, 8'h00, 1'b0, MODE_BIND, 32'h1200_FF34);
        push_request(REQ_QUERY, 8'h00, 1'b0, MODE_CONNECT, 32'h0000_0000);
        // Comment-only load empties the table
        load_string("#\n", txt);
        send_load(txt, 1'b0);
        // Single bad byte ends the load with a syntax error
        txt.delete();
        txt.push_back(8'h00);
        send_load(txt, 1'b0);

        // Random loads with queries around and inside them
        load_no = 0;
        while (n_sent < ITEM_TARGET)
        begin
            repeat ($urandom_range(2, 8))
                send_query();
            build_load(load_no, txt);
            // Keep the run near the item budget: shorten the final load
            while (txt.size() > 1 && n_sent + txt.size() > ITEM_TARGET + 20)
                void'(txt.pop_back());
            send_load(txt, 1'b1);
            load_no++;
        end

        // Drain and let the block settle
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        while (sb.pending_resp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d requests: %0d loads (%0d ok, %0d syntax error, %0d table full)",
                 n_sent, sb.n_loads, sb.n_ok, sb.n_syntax, sb.n_full);
        $display("%0d queries, %0d permitted; %0d results checked",
                 sb.n_queries, sb.n_hits, sb.n_checked);
        if (sb.n_fail == 0 && sb.pending_resp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
